// File: src/eabv_pkg.sv
package eabv_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_W = FRAC_BITS + 2;
  localparam int INT_FRAC = 30;
  localparam int STEPS = 30;
  localparam int CW = 33;
  localparam int ZW = 32;
  localparam int PW = 2 * CW;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30 = 33'sd1073741824;

  typedef logic signed [CW-1:0] q30_t;
  typedef logic signed [OUT_W-1:0] out_t;
  typedef logic [ANGLE_BITS-1:0] ang_t;

  typedef struct packed {
    q30_t x;
    q30_t y;
    logic signed [ZW-1:0] z;
    logic [1:0] quad;
    logic zero;
  } cst_t;

  typedef struct packed {
    q30_t s;
    q30_t c;
  } sc_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    case (i)
      0: atan_turn = 32'sd536870912;
      1: atan_turn = 32'sd316933406;
      2: atan_turn = 32'sd167458907;
      3: atan_turn = 32'sd85004756;
      4: atan_turn = 32'sd42667331;
      5: atan_turn = 32'sd21354465;
      6: atan_turn = 32'sd10679838;
      7: atan_turn = 32'sd5340245;
      8: atan_turn = 32'sd2670163;
      9: atan_turn = 32'sd1335087;
      10: atan_turn = 32'sd667544;
      11: atan_turn = 32'sd333772;
      12: atan_turn = 32'sd166886;
      13: atan_turn = 32'sd83443;
      14: atan_turn = 32'sd41722;
      15: atan_turn = 32'sd20861;
      16: atan_turn = 32'sd10430;
      17: atan_turn = 32'sd5215;
      18: atan_turn = 32'sd2608;
      19: atan_turn = 32'sd1304;
      20: atan_turn = 32'sd652;
      21: atan_turn = 32'sd326;
      22: atan_turn = 32'sd163;
      23: atan_turn = 32'sd81;
      24: atan_turn = 32'sd41;
      25: atan_turn = 32'sd20;
      26: atan_turn = 32'sd10;
      27: atan_turn = 32'sd5;
      28: atan_turn = 32'sd3;
      29: atan_turn = 32'sd1;
      default: atan_turn = 32'sd0;
    endcase
  endfunction

  function automatic cst_t cordic_step(input cst_t a, input int i);
    cst_t r;
    r = a;
    if (!a.z[ZW-1]) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - atan_turn(i);
    end else begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + atan_turn(i);
    end
    return r;
  endfunction

  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< (INT_FRAC - 1));
    return CW'(p >>> INT_FRAC);
  endfunction

  function automatic out_t to_out(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] t;
    logic signed [CW+1:0] lim;
    lim = (CW+2)'(1) <<< FRAC_BITS;
    t = (v + ((CW+2)'(1) <<< (INT_FRAC - FRAC_BITS - 1))) >>> (INT_FRAC - FRAC_BITS);
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return OUT_W'(t);
  endfunction
endpackage

// File: src/eabv_sincos.sv
module eabv_sincos (
  input  logic            clk,
  input  logic            adv,
  input  eabv_pkg::ang_t  ang,
  output eabv_pkg::sc_t   sc
);
  import eabv_pkg::*;
  localparam int PER = 3;
  localparam int NST = STEPS / PER;

  cst_t st_r [NST+1];
  cst_t st_nxt [NST+1];
  sc_t sc_r;
  sc_t sc_nxt;
  logic [31:0] turn;

  assign turn = {ang, {(32-ANGLE_BITS){1'b0}}};

  always_comb begin
    cst_t t;
    st_nxt[0].x = CORDIC_GAIN;
    st_nxt[0].y = '0;
    st_nxt[0].z = {2'b00, turn[29:0]};
    st_nxt[0].quad = turn[31:30];
    st_nxt[0].zero = (turn[29:0] == '0);
    for (int k = 1; k <= NST; k++) begin
      t = st_r[k-1];
      for (int j = 0; j < PER; j++) t = cordic_step(t, (k-1)*PER + j);
      st_nxt[k] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= NST; k++) st_r[k] <= st_nxt[k];
      sc_r <= sc_nxt;
    end
  end

  always_comb begin
    q30_t bs, bc;
    cst_t f;
    f = st_r[NST];
    if (f.zero) begin
      bs = '0;
      bc = ONE_Q30;
    end else begin
      bs = (f.y > ONE_Q30) ? ONE_Q30 : ((f.y < -ONE_Q30) ? -ONE_Q30 : f.y);
      bc = (f.x > ONE_Q30) ? ONE_Q30 : ((f.x < -ONE_Q30) ? -ONE_Q30 : f.x);
    end
    case (f.quad)
      2'd0: begin sc_nxt.s = bs; sc_nxt.c = bc; end
      2'd1: begin sc_nxt.s = bc; sc_nxt.c = -bs; end
      2'd2: begin sc_nxt.s = -bs; sc_nxt.c = -bc; end
      default: begin sc_nxt.s = -bc; sc_nxt.c = bs; end
    endcase
  end

  assign sc = sc_r;
endmodule

// File: src/euler_angles_to_basis_vectors.sv
// Pipeline: an input register, 10 CORDIC stages of three micro-rotations, a quadrant fold,
// two product stages and an output stage. Throughput: one item per cycle; the whole
// pipeline holds while out_stall is high and out_valid is set.
// Reset clears the valid bits only; the datapath holds no state between items.
module euler_angles_to_basis_vectors (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  eabv_pkg::ang_t in_pitch_angle,
  input  eabv_pkg::ang_t in_yaw_angle,
  input  eabv_pkg::ang_t in_roll_angle,
  output logic           out_valid,
  input  logic           out_stall,
  output eabv_pkg::out_t out_forward_x,
  output eabv_pkg::out_t out_forward_y,
  output eabv_pkg::out_t out_forward_z,
  output eabv_pkg::out_t out_right_x,
  output eabv_pkg::out_t out_right_y,
  output eabv_pkg::out_t out_right_z,
  output eabv_pkg::out_t out_up_x,
  output eabv_pkg::out_t out_up_y,
  output eabv_pkg::out_t out_up_z
);
  import eabv_pkg::*;
  localparam int LAT = STEPS / 3 + 5;

  logic [LAT-1:0] vld_r;
  logic adv;
  sc_t p, y, r;
  q30_t srsp_r, crsp_r, cp_r, sp_r, cy_r, sy_r, cr_r, sr_r;
  q30_t m_r [10];
  q30_t m_sr_cy_r, sp_d_r, crcp_d_r;
  out_t o_r [9];

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
  end

  eabv_sincos u_p (.clk(clk), .adv(adv), .ang(in_pitch_angle), .sc(p));
  eabv_sincos u_y (.clk(clk), .adv(adv), .ang(in_yaw_angle), .sc(y));
  eabv_sincos u_r (.clk(clk), .adv(adv), .ang(in_roll_angle), .sc(r));

  always_ff @(posedge clk) begin
    if (adv) begin
      srsp_r <= mulq(r.s, p.s);
      crsp_r <= mulq(r.c, p.s);
      cp_r <= p.c; sp_r <= p.s; cy_r <= y.c; sy_r <= y.s; cr_r <= r.c; sr_r <= r.s;
      m_r[0] <= mulq(cp_r, cy_r);
      m_r[1] <= mulq(cp_r, sy_r);
      m_r[2] <= mulq(srsp_r, cy_r);
      m_r[3] <= mulq(cr_r, sy_r);
      m_r[4] <= mulq(srsp_r, sy_r);
      m_r[5] <= mulq(cr_r, cy_r);
      m_r[6] <= mulq(sr_r, cp_r);
      m_r[7] <= mulq(crsp_r, cy_r);
      m_r[8] <= mulq(sr_r, sy_r);
      m_r[9] <= mulq(crsp_r, sy_r);
      m_sr_cy_r <= mulq(sr_r, cy_r);
      sp_d_r <= sp_r;
      crcp_d_r <= mulq(cr_r, cp_r);
      o_r[0] <= to_out((CW+2)'(m_r[0]));
      o_r[1] <= to_out((CW+2)'(m_r[1]));
      o_r[2] <= to_out(-(CW+2)'(sp_d_r));
      o_r[3] <= to_out((CW+2)'(m_r[3]) - (CW+2)'(m_r[2]));
      o_r[4] <= to_out(-(CW+2)'(m_r[4]) - (CW+2)'(m_r[5]));
      o_r[5] <= to_out(-(CW+2)'(m_r[6]));
      o_r[6] <= to_out((CW+2)'(m_r[7]) + (CW+2)'(m_r[8]));
      o_r[7] <= to_out((CW+2)'(m_r[9]) - (CW+2)'(m_sr_cy_r));
      o_r[8] <= to_out((CW+2)'(crcp_d_r));
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_forward_x = o_r[0];
  assign out_forward_y = o_r[1];
  assign out_forward_z = o_r[2];
  assign out_right_x = o_r[3];
  assign out_right_y = o_r[4];
  assign out_right_z = o_r[5];
  assign out_up_x = o_r[6];
  assign out_up_y = o_r[7];
  assign out_up_z = o_r[8];
endmodule

// File: tb/tb_euler_angles_to_basis_vectors.sv
module tb_euler_angles_to_basis_vectors;
  import eabv_pkg::*;

  typedef struct packed {
    out_t fx, fy, fz, rx, ry, rz, ux, uy, uz;
  } basis_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ang_t in_pitch_angle = '0;
  ang_t in_yaw_angle = '0;
  ang_t in_roll_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_forward_x, out_forward_y, out_forward_z;
  out_t out_right_x, out_right_y, out_right_z;
  out_t out_up_x, out_up_y, out_up_z;

  basis_t expected_basis[$];
  int mismatch_count = 0;
  int result_count = 0;
  int sent_count = 0;
  bit hold_off = 1'b0;
  int burst_left = 0;

  euler_angles_to_basis_vectors dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("timeout after %0d results", result_count);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint shr_arith(longint v, int n);
    return v >>> n;
  endfunction

  task automatic angle_sin_cos(input ang_t a, output longint s, output longint c);
    logic [31:0] turn;
    longint x, y, z, t, bs, bc, one;
    longint atans[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
    one = 64'sd1 << 30;
    turn = {a, 16'h0};
    x = 652032874;
    y = 0;
    z = longint'(turn[29:0]);
    if (z == 0) begin
      bs = 0;
      bc = one;
    end else begin
      for (int i = 0; i < 30; i++) begin
        if (z >= 0) begin
          t = x - shr_arith(y, i);
          y = y + shr_arith(x, i);
          z = z - atans[i];
        end else begin
          t = x + shr_arith(y, i);
          y = y - shr_arith(x, i);
          z = z + atans[i];
        end
        x = t;
      end
      bs = (y > one) ? one : (y < -one) ? -one : y;
      bc = (x > one) ? one : (x < -one) ? -one : x;
    end
    case (turn[31:30])
      2'd0: begin s = bs; c = bc; end
      2'd1: begin s = bc; c = -bs; end
      2'd2: begin s = -bs; c = -bc; end
      default: begin s = -bc; c = bs; end
    endcase
  endtask

  function automatic longint q30_product(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic out_t round_saturate(longint v);
    longint r;
    r = (v + (64'sd1 << 15)) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return out_t'(r);
  endfunction

  task automatic predict_basis(input ang_t p, input ang_t yw, input ang_t r,
                               output basis_t b);
    longint sp, cp, sy, cy, sr, cr, srsp, crsp;
    angle_sin_cos(p, sp, cp);
    angle_sin_cos(yw, sy, cy);
    angle_sin_cos(r, sr, cr);
    srsp = q30_product(sr, sp);
    crsp = q30_product(cr, sp);
    b.fx = round_saturate(q30_product(cp, cy));
    b.fy = round_saturate(q30_product(cp, sy));
    b.fz = round_saturate(-sp);
    b.rx = round_saturate(-q30_product(srsp, cy) + q30_product(cr, sy));
    b.ry = round_saturate(-q30_product(srsp, sy) - q30_product(cr, cy));
    b.rz = round_saturate(-q30_product(sr, cp));
    b.ux = round_saturate(q30_product(crsp, cy) + q30_product(sr, sy));
    b.uy = round_saturate(q30_product(crsp, sy) - q30_product(sr, cy));
    b.uz = round_saturate(q30_product(cr, cp));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %0d want %0d", result_count, what, got, want);
  endtask

  // Sends one orientation, inserting random gaps between bursts.
  task automatic send_angles(input ang_t p, input ang_t yw, input ang_t r);
    basis_t b;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    predict_basis(p, yw, r, b);
    expected_basis = {expected_basis, b};
    in_valid <= 1'b1;
    in_pitch_angle <= p;
    in_yaw_angle <= yw;
    in_roll_angle <= r;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_basis.size() != 0);
  endtask

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (($urandom_range(0, 255) & 8'hC0) == 0) out_stall <= ($urandom_range(0, 3) != 0);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    basis_t w;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_basis.size() == 0) begin
        report_mismatch("unexpected result transfer", 0, 0);
      end else begin
        w = expected_basis.pop_front();
        if (out_forward_x !== w.fx) report_mismatch("forward_x", out_forward_x, w.fx);
        if (out_forward_y !== w.fy) report_mismatch("forward_y", out_forward_y, w.fy);
        if (out_forward_z !== w.fz) report_mismatch("forward_z", out_forward_z, w.fz);
        if (out_right_x !== w.rx) report_mismatch("right_x", out_right_x, w.rx);
        if (out_right_y !== w.ry) report_mismatch("right_y", out_right_y, w.ry);
        if (out_right_z !== w.rz) report_mismatch("right_z", out_right_z, w.rz);
        if (out_up_x !== w.ux) report_mismatch("up_x", out_up_x, w.ux);
        if (out_up_y !== w.uy) report_mismatch("up_y", out_up_y, w.uy);
        if (out_up_z !== w.uz) report_mismatch("up_z", out_up_z, w.uz);
      end
    end
  end

  task automatic test_directed_angles();
    ang_t corners[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                         16'hFFFF, 16'h0001, 16'h3FFF, 16'h2000};
    foreach (corners[i]) send_angles(corners[i], corners[i], corners[i]);
    for (int i = 0; i < 8; i++)
      send_angles(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
    send_angles(16'h0000, 16'hFFFF, 16'h8000);
    send_angles(16'h4001, 16'hBFFF, 16'hC001);
    drain_results();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 60; i++)
        send_angles(ang_t'($urandom), ang_t'($urandom), ang_t'($urandom));
    join
    drain_results();
  endtask

  task automatic test_random_angles(input int n);
    ang_t a[3];
    for (int i = 0; i < n; i++) begin
      foreach (a[k]) begin
        case ($urandom_range(0, 3))
          0: a[k] = ang_t'($urandom_range(0, 3) << 14) + ang_t'($urandom_range(0, 2)) - 16'd1;
          default: a[k] = ang_t'($urandom);
        endcase
      end
      send_angles(a[0], a[1], a[2]);
      if (i % 500 == 499) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_angles();
    test_backpressure();
    test_random_angles(1840);
    repeat (30) @(posedge clk);
    $display("sent %0d orientations, checked %0d basis results", sent_count, result_count);
    $display("covered quadrant edges, full-pipeline stall and random angles");
    if (mismatch_count == 0 && expected_basis.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
